FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: design/pidc_pkg.sv
package pidc_pkg;

   localparam int DATA_W     = 32;
   localparam int GAIN_W     = 24;
   localparam int BOUND_W    = 31;
   localparam int PERIOD_W   = 24;
   localparam int RATE_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 25;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int SUM_W      = 59;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_BOUND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_PERIOD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_RATE      = 3'd5;

   localparam logic [GAIN_W-1:0]   RST_GAIN_P         = 24'd327680;
   localparam logic [GAIN_W-1:0]   RST_GAIN_I         = 24'd1310720;
   localparam logic [GAIN_W-1:0]   RST_GAIN_D         = 24'd0;
   localparam logic [BOUND_W-1:0]  RST_INTEGRAL_BOUND = 31'd19661;
   localparam logic [PERIOD_W-1:0] RST_LOOP_PERIOD    = 24'd16777;
   localparam logic [RATE_W-1:0]   RST_LOOP_RATE      = 24'd256000;

   typedef struct packed {
      logic signed [DATA_W-1:0] err_now;
      logic signed [DATA_W-1:0] err_prev;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive_value;
      logic signed [DATA_W-1:0] integral_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_i;
      logic [GAIN_W-1:0]   gain_d;
      logic [BOUND_W-1:0]  integral_bound;
      logic [PERIOD_W-1:0] loop_period;
      logic [RATE_W-1:0]   loop_rate;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_IN_PERIOD,
      MUL_E_GP,
      MUL_ACC_GI,
      MUL_DIFF_GD,
      MUL_GL_RATE,
      MUL_GH_RATE
   } mul_sel_type;

   typedef enum logic [1:0] {
      SUM_HOLD,
      SUM_LOAD_P,
      SUM_ADD_P,
      SUM_ADD_R8
   } sum_op_type;

   typedef struct packed {
      logic        load_item;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        upd_acc;
      sum_op_type  sum_op;
      logic        gh_load;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

FILE: design/pidc_chan_if.sv
interface pidc_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/pidc_csr.sv
module pidc_csr
   import pidc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx)
            CSR_GAIN_P:         cfg_in.gain_p         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:         cfg_in.gain_i         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:         cfg_in.gain_d         = csr_wdata[GAIN_W-1:0];
            CSR_INTEGRAL_BOUND: cfg_in.integral_bound = csr_wdata[BOUND_W-1:0];
            CSR_LOOP_PERIOD:    cfg_in.loop_period    = csr_wdata[PERIOD_W-1:0];
            CSR_LOOP_RATE:      cfg_in.loop_rate      = csr_wdata[RATE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= RST_GAIN_P;
         cfg_ff.gain_i         <= RST_GAIN_I;
         cfg_ff.gain_d         <= RST_GAIN_D;
         cfg_ff.integral_bound <= RST_INTEGRAL_BOUND;
         cfg_ff.loop_period    <= RST_LOOP_PERIOD;
         cfg_ff.loop_rate      <= RST_LOOP_RATE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/pidc_ctrl.sv
module pidc_ctrl
   import pidc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_P    = 7'b0000010,
      ST_I    = 7'b0000100,
      ST_G    = 7'b0001000,
      ST_GL   = 7'b0010000,
      ST_GH   = 7'b0100000,
      ST_D    = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.mul_en    = 1'b0;
      cmd.mul_sel   = MUL_IN_PERIOD;
      cmd.upd_acc   = 1'b0;
      cmd.sum_op    = SUM_HOLD;
      cmd.gh_load   = 1'b0;
      cmd.out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cmd.mul_en    = 1'b1;
               cmd.mul_sel   = MUL_IN_PERIOD;
               state_in      = ST_P;
            end
         end
         ST_P: begin
            cmd.upd_acc = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_E_GP;
            state_in    = ST_I;
         end
         ST_I: begin
            cmd.sum_op  = SUM_LOAD_P;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ACC_GI;
            state_in    = ST_G;
         end
         ST_G: begin
            cmd.sum_op  = SUM_ADD_P;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DIFF_GD;
            state_in    = ST_GL;
         end
         ST_GL: begin
            cmd.gh_load = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GL_RATE;
            state_in    = ST_GH;
         end
         ST_GH: begin
            cmd.sum_op  = SUM_ADD_R8;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GH_RATE;
            state_in    = ST_D;
         end
         ST_D: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/pidc_dp.sv
module pidc_dp
   import pidc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  cmd_type         cmd,
   output status_type      status,
   input  req_payload_type req_payload,
   pidc_chan_if.source     rsp_if
);

   localparam logic signed [SUM_W-1:0] DRV_MAX = 59'sd2147483647;
   localparam logic signed [SUM_W-1:0] DRV_MIN = -59'sd2147483648;

   logic signed [DATA_W-1:0]  e_ff;
   logic signed [DATA_W-1:0]  e_in;
   logic signed [DATA_W:0]    diff_ff;
   logic signed [DATA_W:0]    diff_in;
   logic signed [DATA_W-1:0]  acc_ff;
   logic signed [DATA_W-1:0]  acc_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [17:0]        gh_ff;
   logic signed [17:0]        gh_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_payload_type           rsp_data_ff;
   rsp_payload_type           rsp_data_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [34:0]        acc_sum;
   logic signed [34:0]        bound_pos;
   logic signed [34:0]        bound_neg;
   logic signed [SUM_W-1:0]   total;
   logic signed [DATA_W-1:0]  drive_sat;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         MUL_IN_PERIOD: begin
            mul_a = {req_payload.err_now[DATA_W-1], req_payload.err_now};
            mul_b = {1'b0, cfg.loop_period};
         end
         MUL_E_GP: begin
            mul_a = {e_ff[DATA_W-1], e_ff};
            mul_b = {1'b0, cfg.gain_p};
         end
         MUL_ACC_GI: begin
            mul_a = {acc_ff[DATA_W-1], acc_ff};
            mul_b = {1'b0, cfg.gain_i};
         end
         MUL_DIFF_GD: begin
            mul_a = diff_ff;
            mul_b = {1'b0, cfg.gain_d};
         end
         MUL_GL_RATE: begin
            mul_a = {9'b0, prod_ff[39:16]};
            mul_b = {1'b0, cfg.loop_rate};
         end
         MUL_GH_RATE: begin
            mul_a = {{15{gh_ff[17]}}, gh_ff};
            mul_b = {1'b0, cfg.loop_rate};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign acc_sum   = {{3{acc_ff[DATA_W-1]}}, acc_ff} + {prod_ff[PROD_W-1], prod_ff[57:24]};
   assign bound_pos = {4'b0, cfg.integral_bound};
   assign bound_neg = -bound_pos;

   always_comb begin
      if (acc_sum > bound_pos) begin
         acc_in = bound_pos[DATA_W-1:0];
      end else if (acc_sum < bound_neg) begin
         acc_in = bound_neg[DATA_W-1:0];
      end else begin
         acc_in = acc_sum[DATA_W-1:0];
      end
      if (!cmd.upd_acc) begin
         acc_in = acc_ff;
      end
   end

   always_comb begin
      case (cmd.sum_op)
         SUM_LOAD_P: sum_in = {{17{prod_ff[PROD_W-1]}}, prod_ff[57:16]};
         SUM_ADD_P:  sum_in = sum_ff + {{17{prod_ff[PROD_W-1]}}, prod_ff[57:16]};
         SUM_ADD_R8: sum_in = sum_ff + {{9{prod_ff[PROD_W-1]}}, prod_ff[57:8]};
         default:    sum_in = sum_ff;
      endcase
   end

   assign total = sum_ff + {prod_ff[42:0], 16'b0};

   always_comb begin
      if (total > DRV_MAX) begin
         drive_sat = DRV_MAX[DATA_W-1:0];
      end else if (total < DRV_MIN) begin
         drive_sat = DRV_MIN[DATA_W-1:0];
      end else begin
         drive_sat = total[DATA_W-1:0];
      end
   end

   assign e_in    = cmd.load_item ? req_payload.err_now : e_ff;
   assign diff_in = cmd.load_item
                  ? {req_payload.err_now[DATA_W-1], req_payload.err_now}
                    - {req_payload.err_prev[DATA_W-1], req_payload.err_prev}
                  : diff_ff;
   assign prod_in = cmd.mul_en ? mul_p : prod_ff;
   assign gh_in   = cmd.gh_load ? prod_ff[57:40] : gh_ff;

   assign status.out_busy = rsp_valid_ff && !rsp_if.ready;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.drive_value  = drive_sat;
         rsp_data_in.integral_out = acc_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      gh_ff       <= gh_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

endmodule

FILE: design/pid_with_integral_clamp.sv
// An accepted item steps through states ST_P, ST_I, ST_G, ST_GL, ST_GH and ST_D, after which
// its result is registered on rsp_if. Only one item is in flight at a time, as the single 33x25
// multiplier takes six products per item in sequence. A result waiting in the output register
// does not stop the next item being accepted, but holds it in ST_D until the register is free.
// Reset is synchronous and active high; it restores the default gains, bound,
// period and rate, clears the integral and empties the output register.
`include "assert_macros.svh"

module pid_with_integral_clamp
   import pidc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pidc_chan_if.sink             req_if,
   pidc_chan_if.source           rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   pidc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pidc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_if.payload),
      .rsp_if      (rsp_if)
   );

   assign req_if.ready = req_ready;

   logic signed [DATA_W:0] bound_hi;
   logic signed [DATA_W:0] bound_lo;
   logic signed [DATA_W:0] int_out_ext;
   logic                   int_in_bound;
   logic                   req_take;

   assign bound_hi     = {2'b0, cfg.integral_bound};
   assign bound_lo     = -bound_hi;
   assign int_out_ext  = {rsp_if.payload.integral_out[DATA_W-1], rsp_if.payload.integral_out};
   assign int_in_bound = (int_out_ext <= bound_hi) && (int_out_ext >= bound_lo);
   assign req_take     = req_if.valid && req_if.ready;

   // The reported integral always lies inside the configured bound.
   `ASSERT_IMPLIES(a_int_clamped, clock, reset, rsp_if.valid, int_in_bound)
   // The block works on one item at a time.
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, !req_if.ready)
   // Each fresh result on rsp_if is checked against the cycle in which its item was taken.
   `ASSERT_IMPLIES(a_latency, clock, reset, $rose(rsp_if.valid), $past(req_take, 7))

endmodule

FILE: dv/tb_pid_with_integral_clamp.sv
`timescale 1ns / 1ps

module tb_pid_with_integral_clamp;
   import pidc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 162;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [CSR_DATA_W-1:0] CSR_ALL_ONES = '1;
   localparam logic signed [DATA_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] ERR_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] ERR_ONE = 32'sh0001_0000;

   class drive_predictor;
      cfg_type cfg;
      int integral;
      rsp_payload_type expected_drives[$];
      int mismatches;
      int results_seen;

      function new();
         cfg.gain_p = RST_GAIN_P;
         cfg.gain_i = RST_GAIN_I;
         cfg.gain_d = RST_GAIN_D;
         cfg.integral_bound = RST_INTEGRAL_BOUND;
         cfg.loop_period = RST_LOOP_PERIOD;
         cfg.loop_rate = RST_LOOP_RATE;
         integral = 0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_GAIN_P: cfg.gain_p = data[GAIN_W-1:0];
            CSR_GAIN_I: cfg.gain_i = data[GAIN_W-1:0];
            CSR_GAIN_D: cfg.gain_d = data[GAIN_W-1:0];
            CSR_INTEGRAL_BOUND: cfg.integral_bound = data[BOUND_W-1:0];
            CSR_LOOP_PERIOD: cfg.loop_period = data[PERIOD_W-1:0];
            CSR_LOOP_RATE: cfg.loop_rate = data[RATE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_error_sample(req_payload_type item);
         longint e;
         longint ep;
         longint bound;
         longint acc;
         longint p;
         longint ig;
         longint g;
         longint d;
         longint sum;
         rsp_payload_type drive;
         e = longint'(signed'(item.err_now));
         ep = longint'(signed'(item.err_prev));
         bound = longint'(cfg.integral_bound);
         acc = longint'(integral) + ((e * longint'(cfg.loop_period)) >>> 24);
         if (acc > bound) acc = bound;
         if (acc < -bound) acc = -bound;
         integral = int'(acc);
         p = (e * longint'(cfg.gain_p)) >>> 16;
         ig = (acc * longint'(cfg.gain_i)) >>> 16;
         // The rate is split into its integer and fraction parts so that no product overflows.
         g = ((e - ep) * longint'(cfg.gain_d)) >>> 16;
         d = g * longint'(cfg.loop_rate[RATE_W-1:8]) + ((g * longint'(cfg.loop_rate[7:0])) >>> 8);
         sum = p + ig + d;
         if (sum > longint'(ERR_MAX)) sum = longint'(ERR_MAX);
         if (sum < longint'(ERR_MIN)) sum = longint'(ERR_MIN);
         drive.drive_value = sum[31:0];
         drive.integral_out = integral;
         expected_drives.push_back(drive);
      endfunction

      function void check_drive(rsp_payload_type got);
         rsp_payload_type want;
         results_seen++;
         if (expected_drives.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected: drive %0d, integral %0d",
                     $time, got.drive_value, got.integral_out);
            return;
         end
         want = expected_drives.pop_front();
         if (got.drive_value !== want.drive_value) begin
            mismatches++;
            $display("%0t: drive_value expected %0d, actual %0d",
                     $time, want.drive_value, got.drive_value);
         end
         if (got.integral_out !== want.integral_out) begin
            mismatches++;
            $display("%0t: integral_out expected %0d, actual %0d",
                     $time, want.integral_out, got.integral_out);
         end
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic steady;
   int idle_cycles;
   int sent_count;
   int settings_count;
   logic signed [DATA_W-1:0] last_err;
   drive_predictor tracker;

   pidc_chan_if #(.payload_type(req_payload_type)) req_if ();
   pidc_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   pid_with_integral_clamp dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_we(csr_we),
      .csr_idx(csr_idx),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 35);
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_if.valid && req_if.ready) tracker.note_error_sample(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) tracker.check_drive(rsp_if.payload);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      @(posedge clock);
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   task automatic set_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_register(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input logic signed [DATA_W-1:0] now_err,
                            input logic signed [DATA_W-1:0] prev_err);
      req_payload_type item;
      item.err_now = now_err;
      item.err_prev = prev_err;
      if (!steady) begin
         while ($urandom_range(99) < 35) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] rand_error();
      case ($urandom_range(4))
         0: return ($urandom_range(1) == 1) ? ERR_MAX : ERR_MIN;
         1: return $urandom;
         2: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
         default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_reg_value();
      case ($urandom_range(9))
         0: return '0;
         1: return CSR_ALL_ONES;
         2, 3: return CSR_DATA_W'($urandom_range(1, 1 << 18));
         4: return CSR_DATA_W'($urandom_range(1, 1 << 24));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   task automatic random_settings(input bit matched_rate);
      logic [CSR_DATA_W-1:0] period;
      set_csr(CSR_GAIN_P, rand_reg_value());
      set_csr(CSR_GAIN_I, rand_reg_value());
      set_csr(CSR_GAIN_D, rand_reg_value());
      set_csr(CSR_INTEGRAL_BOUND, rand_reg_value());
      if (matched_rate) begin
         period = CSR_DATA_W'($urandom_range(257, 1 << 20));
         set_csr(CSR_LOOP_PERIOD, period);
         set_csr(CSR_LOOP_RATE, CSR_DATA_W'((64'd1 << 32) / period));
      end else begin
         set_csr(CSR_LOOP_PERIOD, rand_reg_value());
         set_csr(CSR_LOOP_RATE, rand_reg_value());
      end
      settings_count++;
   endtask

   task automatic run_random(input int count);
      logic signed [DATA_W-1:0] now_err;
      logic signed [DATA_W-1:0] prev_err;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 70) begin
            prev_err = last_err;
            if ($urandom_range(3) == 0) begin
               now_err = rand_error();
            end else begin
               now_err = last_err + (int'($urandom_range(0, 1 << 17)) - (1 << 16));
            end
         end else begin
            prev_err = rand_error();
            now_err = rand_error();
         end
         send_item(now_err, prev_err);
         last_err = now_err;
      end
   endtask

   initial begin
      tracker = new();
      sent_count = 0;
      settings_count = 1;
      last_err = '0;
      reset <= 1'b1;
      steady <= 1'b0;
      csr_we <= 1'b0;
      csr_idx <= '0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item('0, '0);
      send_item(ERR_MAX, ERR_MIN);
      send_item(ERR_MIN, ERR_MAX);
      send_item(-32'sd1, -32'sd1);
      send_item(ERR_ONE, '0);
      settle();

      // Writing all ones also checks that wide data is cut to each register's width.
      set_csr(CSR_GAIN_P, CSR_ALL_ONES);
      set_csr(CSR_GAIN_I, CSR_ALL_ONES);
      set_csr(CSR_GAIN_D, CSR_ALL_ONES);
      set_csr(CSR_INTEGRAL_BOUND, CSR_ALL_ONES);
      set_csr(CSR_LOOP_PERIOD, CSR_ALL_ONES);
      set_csr(CSR_LOOP_RATE, CSR_ALL_ONES);
      settings_count++;
      send_item(ERR_MAX, ERR_MIN);
      send_item(ERR_MIN, ERR_MAX);
      send_item(ERR_MIN, ERR_MIN);
      send_item(ERR_MAX, ERR_MAX);
      settle();

      set_csr(CSR_LOOP_PERIOD, '0);
      send_item(ERR_MAX, '0);
      send_item(ERR_MIN, '0);
      settle();
      set_csr(CSR_INTEGRAL_BOUND, '0);
      send_item(ERR_MAX, '0);
      settle();
      set_csr(CSR_LOOP_RATE, '0);
      send_item(ERR_MAX, ERR_MIN);
      settle();
      set_csr(CSR_SPARE_LO, CSR_ALL_ONES);
      set_csr(CSR_SPARE_HI, '0);
      send_item(ERR_MIN, ERR_MAX);
      settle();
      set_csr(CSR_GAIN_P, '0);
      set_csr(CSR_GAIN_I, '0);
      set_csr(CSR_GAIN_D, '0);
      settings_count++;
      send_item(ERR_MAX, ERR_MIN);
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         steady <= (ph == 4);
         random_settings(ph % 3 == 1);
         run_random(ITEMS_PER_PHASE);
         settle();
      end

      $display("Sent %0d items under %0d register settings and compared %0d results.",
               sent_count, settings_count, tracker.results_seen);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
